[src/ift_pkg.sv]
// Shared types, codes and the sequencer microprogram of the IMU frame transform.
package ift_pkg;

  localparam int ACC_W = 64;
  localparam int PC_W  = 6;
  localparam logic [PC_W-1:0] COV_PC = 6'd20;

  localparam logic       ACT_SAMPLE  = 1'b0;
  localparam logic       ACT_COV     = 1'b1;
  localparam logic       KIND_SAMPLE = 1'b0;
  localparam logic       KIND_COV    = 1'b1;
  localparam logic [1:0] ROW_0       = 2'd0;
  localparam logic [1:0] ROW_1       = 2'd1;
  localparam logic [1:0] ROW_2       = 2'd2;

  localparam logic [2:0] CFG_QW = 3'd0;
  localparam logic [2:0] CFG_QX = 3'd1;
  localparam logic [2:0] CFG_QY = 3'd2;
  localparam logic [2:0] CFG_QZ = 3'd3;
  localparam logic [2:0] CFG_OX = 3'd4;
  localparam logic [2:0] CFG_OY = 3'd5;
  localparam logic [2:0] CFG_OZ = 3'd6;

  typedef enum logic [5:0] {
    S_ZERO,
    S_QW, S_QX, S_QY, S_QZ,
    S_M00, S_M01, S_M02, S_M10, S_M11, S_M12, S_M20, S_M21, S_M22,
    S_V0, S_V1, S_V2,
    S_R0, S_R1, S_R2,
    S_IW, S_IX, S_IY, S_IZ,
    S_OX, S_OY, S_OZ,
    S_W0, S_W1, S_W2,
    S_C0, S_C1, S_C2,
    S_CS0, S_CS1, S_CS2, S_CS3, S_CS4, S_CS5,
    S_T00, S_T01, S_T02, S_T10, S_T11, S_T12, S_T20, S_T21, S_T22
  } src_e;

  typedef enum logic [1:0] {K29, K30, KF} shift_e;

  typedef enum logic [3:0] {
    D_MA, D_MB, D_MC, D_W, D_AT, D_C, D_D, D_QO,
    D_T0, D_T1, D_T2, D_P0, D_P1, D_P2
  } dest_e;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_ISSUE = 4'b0010,
    ST_DRAIN = 4'b0100,
    ST_WRITE = 4'b1000
  } state_e;

  typedef struct packed {
    src_e   a;
    src_e   b;
    logic   neg;
    logic   bias;
    shift_e sh;
  } lane_op_t;

  typedef struct packed {
    logic     valid;
    logic     first;
    lane_op_t op;
  } lane_ctl_t;

  typedef struct packed {
    lane_op_t [3:0] lane;
    logic           first;
    logic           last;
    dest_e          dest;
  } uop_t;

  function automatic lane_op_t lop(src_e a, src_e b, logic neg, shift_e sh, logic bias);
    lane_op_t o;
    o.a = a;
    o.b = b;
    o.neg = neg;
    o.sh = sh;
    o.bias = bias;
    return o;
  endfunction

  function automatic src_e src_at(src_e base, int ofs);
    return src_e'(6'(int'(base) + ofs));
  endfunction

  // One issue slot per entry: every lane multiplies one term and accumulates it.
  function automatic uop_t uop(logic [PC_W-1:0] pc);
    uop_t u;
    for (int l = 0; l < 4; l++) begin
      u.lane[l] = lop(S_ZERO, S_ZERO, 1'b0, K30, 1'b0);
    end
    u.first = 1'b0;
    u.last  = 1'b0;
    u.dest  = D_MA;
    case (pc)
      6'd0: begin
        u.first = 1'b1;
        u.lane[0] = lop(S_QY, S_QY, 1'b1, K29, 1'b1);
        u.lane[1] = lop(S_QX, S_QY, 1'b0, K29, 1'b0);
        u.lane[2] = lop(S_QX, S_QZ, 1'b0, K29, 1'b0);
        u.lane[3] = lop(S_QX, S_QY, 1'b0, K29, 1'b0);
      end
      6'd1: begin
        u.last = 1'b1;
        u.dest = D_MA;
        u.lane[0] = lop(S_QZ, S_QZ, 1'b1, K29, 1'b0);
        u.lane[1] = lop(S_QW, S_QZ, 1'b1, K29, 1'b0);
        u.lane[2] = lop(S_QW, S_QY, 1'b0, K29, 1'b0);
        u.lane[3] = lop(S_QW, S_QZ, 1'b0, K29, 1'b0);
      end
      6'd2: begin
        u.first = 1'b1;
        u.lane[0] = lop(S_QX, S_QX, 1'b1, K29, 1'b1);
        u.lane[1] = lop(S_QY, S_QZ, 1'b0, K29, 1'b0);
        u.lane[2] = lop(S_QX, S_QZ, 1'b0, K29, 1'b0);
        u.lane[3] = lop(S_QY, S_QZ, 1'b0, K29, 1'b0);
      end
      6'd3: begin
        u.last = 1'b1;
        u.dest = D_MB;
        u.lane[0] = lop(S_QZ, S_QZ, 1'b1, K29, 1'b0);
        u.lane[1] = lop(S_QW, S_QX, 1'b1, K29, 1'b0);
        u.lane[2] = lop(S_QW, S_QY, 1'b1, K29, 1'b0);
        u.lane[3] = lop(S_QW, S_QX, 1'b0, K29, 1'b0);
      end
      6'd4: begin
        u.first = 1'b1;
        u.lane[0] = lop(S_QX, S_QX, 1'b1, K29, 1'b1);
      end
      6'd5: begin
        u.last = 1'b1;
        u.dest = D_MC;
        u.lane[0] = lop(S_QY, S_QY, 1'b1, K29, 1'b0);
      end
      6'd12: begin
        u.first = 1'b1;
        u.lane[0] = lop(S_W1, S_OZ, 1'b0, KF, 1'b0);
        u.lane[1] = lop(S_W2, S_OX, 1'b0, KF, 1'b0);
        u.lane[2] = lop(S_W0, S_OY, 1'b0, KF, 1'b0);
      end
      6'd13: begin
        u.last = 1'b1;
        u.dest = D_C;
        u.lane[0] = lop(S_W2, S_OY, 1'b1, KF, 1'b0);
        u.lane[1] = lop(S_W0, S_OZ, 1'b1, KF, 1'b0);
        u.lane[2] = lop(S_W1, S_OX, 1'b1, KF, 1'b0);
      end
      6'd14: begin
        u.first = 1'b1;
        u.lane[0] = lop(S_W1, S_C2, 1'b0, KF, 1'b0);
        u.lane[1] = lop(S_W2, S_C0, 1'b0, KF, 1'b0);
        u.lane[2] = lop(S_W0, S_C1, 1'b0, KF, 1'b0);
      end
      6'd15: begin
        u.last = 1'b1;
        u.dest = D_D;
        u.lane[0] = lop(S_W2, S_C1, 1'b1, KF, 1'b0);
        u.lane[1] = lop(S_W0, S_C2, 1'b1, KF, 1'b0);
        u.lane[2] = lop(S_W1, S_C0, 1'b1, KF, 1'b0);
      end
      6'd16: begin
        u.first = 1'b1;
        u.lane[0] = lop(S_QW, S_IW, 1'b0, K30, 1'b0);
        u.lane[1] = lop(S_QW, S_IX, 1'b0, K30, 1'b0);
        u.lane[2] = lop(S_QW, S_IY, 1'b0, K30, 1'b0);
        u.lane[3] = lop(S_QW, S_IZ, 1'b0, K30, 1'b0);
      end
      6'd17: begin
        u.lane[0] = lop(S_QX, S_IX, 1'b1, K30, 1'b0);
        u.lane[1] = lop(S_QX, S_IW, 1'b0, K30, 1'b0);
        u.lane[2] = lop(S_QX, S_IZ, 1'b1, K30, 1'b0);
        u.lane[3] = lop(S_QX, S_IY, 1'b0, K30, 1'b0);
      end
      6'd18: begin
        u.lane[0] = lop(S_QY, S_IY, 1'b1, K30, 1'b0);
        u.lane[1] = lop(S_QY, S_IZ, 1'b0, K30, 1'b0);
        u.lane[2] = lop(S_QY, S_IW, 1'b0, K30, 1'b0);
        u.lane[3] = lop(S_QY, S_IX, 1'b1, K30, 1'b0);
      end
      6'd19: begin
        u.last = 1'b1;
        u.dest = D_QO;
        u.lane[0] = lop(S_QZ, S_IZ, 1'b1, K30, 1'b0);
        u.lane[1] = lop(S_QZ, S_IY, 1'b1, K30, 1'b0);
        u.lane[2] = lop(S_QZ, S_IX, 1'b0, K30, 1'b0);
        u.lane[3] = lop(S_QZ, S_IW, 1'b0, K30, 1'b0);
      end
      default: begin
      end
    endcase
    // matrix times rate, matrix times acceleration
    for (int j = 0; j < 3; j++) begin
      if (pc == 6'(6 + j) || pc == 6'(9 + j)) begin
        u.first = (j == 0);
        u.last  = (j == 2);
        u.dest  = (pc < 6'd9) ? D_W : D_AT;
        for (int i = 0; i < 3; i++) begin
          u.lane[i] = lop(src_at(S_M00, 3 * i + j),
                          src_at((pc < 6'd9) ? S_R0 : S_V0, j), 1'b0, K30, 1'b0);
        end
      end
    end
    // covariance: T = M*C column by column, then each row of T times M^T
    for (int j = 0; j < 3; j++) begin
      for (int k = 0; k < 3; k++) begin
        if (pc == 6'(20 + 3 * j + k)) begin
          u.first = (k == 0);
          u.last  = (k == 2);
          u.dest  = dest_e'(4'(int'(D_T0) + j));
          for (int i = 0; i < 3; i++) begin
            u.lane[i] = lop(src_at(S_M00, 3 * i + k),
                            (k == 2) ? src_at(S_V0, j) : src_at(S_CS0, 3 * k + j),
                            1'b0, K30, 1'b0);
          end
        end
        if (pc == 6'(29 + 3 * j + k)) begin
          u.first = (k == 0);
          u.last  = (k == 2);
          u.dest  = dest_e'(4'(int'(D_P0) + j));
          for (int i = 0; i < 3; i++) begin
            u.lane[i] = lop(src_at(S_M00, 3 * i + k), src_at(S_T00, 3 * j + k),
                            1'b0, K30, 1'b0);
          end
        end
      end
    end
    return u;
  endfunction

endpackage

[src/imu_frame_transform.sv]
// IMU frame transform: sequencer, operand and result registers, four lanes.
// Sample: 8 passes from the accepted beat to the result beat, each of issue states plus
// a drain and a write state; a stalled result beat holds the write of an output pass.
// Covariance row 2: the matrix and T passes run first, then one pass per row beat.
// Rows 0 and 1 are only stored. One item in flight; in_stall_o while busy.
// Reset clears control, loads identity mounting and zero lever arm, not the rows.
module imu_frame_transform #(
  parameter int DATA_WIDTH = 32,
  parameter int FRAC_BITS  = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_idx_i,
  input  logic [31:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               action_i,
  input  logic signed [31:0] vec_x_i,
  input  logic signed [31:0] vec_y_i,
  input  logic signed [31:0] vec_z_i,
  input  logic signed [31:0] rate_x_i,
  input  logic signed [31:0] rate_y_i,
  input  logic signed [31:0] rate_z_i,
  input  logic signed [31:0] quat_w_i,
  input  logic signed [31:0] quat_x_i,
  input  logic signed [31:0] quat_y_i,
  input  logic signed [31:0] quat_z_i,
  input  logic [1:0]         row_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic               kind_o,
  output logic signed [31:0] out_vec_x_o,
  output logic signed [31:0] out_vec_y_o,
  output logic signed [31:0] out_vec_z_o,
  output logic signed [31:0] out_rate_x_o,
  output logic signed [31:0] out_rate_y_o,
  output logic signed [31:0] out_rate_z_o,
  output logic signed [31:0] out_quat_w_o,
  output logic signed [31:0] out_quat_x_o,
  output logic signed [31:0] out_quat_y_o,
  output logic signed [31:0] out_quat_z_o,
  output logic               last_o
);

  localparam int VEC_W = (DATA_WIDTH < 32) ? DATA_WIDTH : 32;

  ift_pkg::state_e                state_q, state_d;
  logic [ift_pkg::PC_W-1:0]       pc_q, pc_d;
  ift_pkg::dest_e                 dest_q, dest_d;
  ift_pkg::uop_t                  u;

  logic signed [31:0] qw_q, qx_q, qy_q, qz_q, ox_q, oy_q, oz_q;
  logic signed [31:0] vec_q [3];
  logic signed [31:0] rate_q [3];
  logic signed [31:0] quat_q [4];
  logic               action_q;
  logic signed [31:0] cs_q [6];
  logic signed [31:0] m_q [9];
  logic signed [31:0] w_q [3];
  logic signed [31:0] at_q [3];
  logic signed [31:0] c_q [3];
  logic signed [31:0] d_q [3];
  logic signed [31:0] t_q [9];

  logic               out_valid_q;
  logic               kind_q, last_q;
  logic signed [31:0] ovec_q [3];
  logic signed [31:0] orate_q [3];
  logic signed [31:0] oquat_q [4];

  ift_pkg::lane_ctl_t               ctl [4];
  logic signed [31:0]               opa [4];
  logic signed [31:0]               opb [4];
  logic signed [ift_pkg::ACC_W-1:0] acc [4];
  logic signed [31:0]               res [4];
  logic signed [31:0]               accel [3];

  logic accept_in, is_out, wide, write_en;

  function automatic logic signed [31:0] pick(ift_pkg::src_e s);
    case (s)
      ift_pkg::S_QW:  pick = qw_q;
      ift_pkg::S_QX:  pick = qx_q;
      ift_pkg::S_QY:  pick = qy_q;
      ift_pkg::S_QZ:  pick = qz_q;
      ift_pkg::S_M00: pick = m_q[0];
      ift_pkg::S_M01: pick = m_q[1];
      ift_pkg::S_M02: pick = m_q[2];
      ift_pkg::S_M10: pick = m_q[3];
      ift_pkg::S_M11: pick = m_q[4];
      ift_pkg::S_M12: pick = m_q[5];
      ift_pkg::S_M20: pick = m_q[6];
      ift_pkg::S_M21: pick = m_q[7];
      ift_pkg::S_M22: pick = m_q[8];
      ift_pkg::S_V0:  pick = vec_q[0];
      ift_pkg::S_V1:  pick = vec_q[1];
      ift_pkg::S_V2:  pick = vec_q[2];
      ift_pkg::S_R0:  pick = rate_q[0];
      ift_pkg::S_R1:  pick = rate_q[1];
      ift_pkg::S_R2:  pick = rate_q[2];
      ift_pkg::S_IW:  pick = quat_q[0];
      ift_pkg::S_IX:  pick = quat_q[1];
      ift_pkg::S_IY:  pick = quat_q[2];
      ift_pkg::S_IZ:  pick = quat_q[3];
      ift_pkg::S_OX:  pick = ox_q;
      ift_pkg::S_OY:  pick = oy_q;
      ift_pkg::S_OZ:  pick = oz_q;
      ift_pkg::S_W0:  pick = w_q[0];
      ift_pkg::S_W1:  pick = w_q[1];
      ift_pkg::S_W2:  pick = w_q[2];
      ift_pkg::S_C0:  pick = c_q[0];
      ift_pkg::S_C1:  pick = c_q[1];
      ift_pkg::S_C2:  pick = c_q[2];
      ift_pkg::S_CS0: pick = cs_q[0];
      ift_pkg::S_CS1: pick = cs_q[1];
      ift_pkg::S_CS2: pick = cs_q[2];
      ift_pkg::S_CS3: pick = cs_q[3];
      ift_pkg::S_CS4: pick = cs_q[4];
      ift_pkg::S_CS5: pick = cs_q[5];
      ift_pkg::S_T00: pick = t_q[0];
      ift_pkg::S_T01: pick = t_q[1];
      ift_pkg::S_T02: pick = t_q[2];
      ift_pkg::S_T10: pick = t_q[3];
      ift_pkg::S_T11: pick = t_q[4];
      ift_pkg::S_T12: pick = t_q[5];
      ift_pkg::S_T20: pick = t_q[6];
      ift_pkg::S_T21: pick = t_q[7];
      ift_pkg::S_T22: pick = t_q[8];
      default:        pick = '0;
    endcase
  endfunction

  assign u          = ift_pkg::uop(pc_q);
  assign in_stall_o = (state_q != ift_pkg::ST_IDLE);
  assign accept_in  = in_valid_i && (state_q == ift_pkg::ST_IDLE);
  assign is_out     = (dest_q == ift_pkg::D_QO) || (dest_q == ift_pkg::D_P0) ||
                      (dest_q == ift_pkg::D_P1) || (dest_q == ift_pkg::D_P2);
  assign wide       = (dest_q == ift_pkg::D_MA) || (dest_q == ift_pkg::D_MB) ||
                      (dest_q == ift_pkg::D_MC) || (dest_q == ift_pkg::D_QO);
  assign write_en   = (state_q == ift_pkg::ST_WRITE) &&
                      (!is_out || !out_valid_q || !out_stall_i);

  always_comb begin
    for (int l = 0; l < 4; l++) begin
      ctl[l].valid = (state_q == ift_pkg::ST_ISSUE);
      ctl[l].first = u.first;
      ctl[l].op    = u.lane[l];
      opa[l]       = pick(u.lane[l].a);
      opb[l]       = pick(u.lane[l].b);
    end
  end

  for (genvar l = 0; l < 4; l++) begin : g_lane
    ift_lane #(.FRAC_BITS(FRAC_BITS)) u_lane (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctl_i  (ctl[l]),
      .a_i    (opa[l]),
      .b_i    (opb[l]),
      .acc_o  (acc[l])
    );
  end

  ift_merge #(.VEC_W(VEC_W)) u_merge (
    .acc_i   (acc),
    .wide_i  (wide),
    .at_i    (at_q),
    .dd_i    (d_q),
    .res_o   (res),
    .accel_o (accel)
  );

  always_comb begin
    state_d = state_q;
    pc_d    = pc_q;
    dest_d  = dest_q;
    case (state_q)
      ift_pkg::ST_IDLE: begin
        if (accept_in && (action_i == ift_pkg::ACT_SAMPLE || row_i == ift_pkg::ROW_2)) begin
          state_d = ift_pkg::ST_ISSUE;
          pc_d    = '0;
        end
      end
      ift_pkg::ST_ISSUE: begin
        if (u.last) begin
          dest_d  = u.dest;
          state_d = ift_pkg::ST_DRAIN;
        end else begin
          pc_d = pc_q + 1'b1;
        end
      end
      ift_pkg::ST_DRAIN: begin
        state_d = ift_pkg::ST_WRITE;
      end
      ift_pkg::ST_WRITE: begin
        if (write_en) begin
          if (dest_q == ift_pkg::D_QO || dest_q == ift_pkg::D_P2) begin
            state_d = ift_pkg::ST_IDLE;
          end else if (dest_q == ift_pkg::D_MC && action_q == ift_pkg::ACT_COV) begin
            // branch to the covariance passes
            pc_d    = ift_pkg::COV_PC;
            state_d = ift_pkg::ST_ISSUE;
          end else begin
            pc_d    = pc_q + 1'b1;
            state_d = ift_pkg::ST_ISSUE;
          end
        end
      end
      default: state_d = ift_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ift_pkg::ST_IDLE;
      pc_q        <= '0;
      dest_q      <= ift_pkg::D_MA;
      out_valid_q <= 1'b0;
      qw_q        <= 32'sh4000_0000;
      qx_q        <= '0;
      qy_q        <= '0;
      qz_q        <= '0;
      ox_q        <= '0;
      oy_q        <= '0;
      oz_q        <= '0;
    end else begin
      state_q <= state_d;
      pc_q    <= pc_d;
      dest_q  <= dest_d;
      if (write_en && is_out) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          ift_pkg::CFG_QW: qw_q <= cfg_data_i;
          ift_pkg::CFG_QX: qx_q <= cfg_data_i;
          ift_pkg::CFG_QY: qy_q <= cfg_data_i;
          ift_pkg::CFG_QZ: qz_q <= cfg_data_i;
          ift_pkg::CFG_OX: ox_q <= cfg_data_i;
          ift_pkg::CFG_OY: oy_q <= cfg_data_i;
          ift_pkg::CFG_OZ: oz_q <= cfg_data_i;
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_in) begin
      action_q  <= action_i;
      vec_q[0]  <= vec_x_i;
      vec_q[1]  <= vec_y_i;
      vec_q[2]  <= vec_z_i;
      rate_q[0] <= rate_x_i;
      rate_q[1] <= rate_y_i;
      rate_q[2] <= rate_z_i;
      quat_q[0] <= quat_w_i;
      quat_q[1] <= quat_x_i;
      quat_q[2] <= quat_y_i;
      quat_q[3] <= quat_z_i;
      if (action_i == ift_pkg::ACT_COV && row_i == ift_pkg::ROW_0) begin
        cs_q[0] <= vec_x_i;
        cs_q[1] <= vec_y_i;
        cs_q[2] <= vec_z_i;
      end
      if (action_i == ift_pkg::ACT_COV && row_i == ift_pkg::ROW_1) begin
        cs_q[3] <= vec_x_i;
        cs_q[4] <= vec_y_i;
        cs_q[5] <= vec_z_i;
      end
    end
    if (write_en) begin
      case (dest_q)
        ift_pkg::D_MA: for (int i = 0; i < 4; i++) m_q[i] <= res[i];
        ift_pkg::D_MB: for (int i = 0; i < 4; i++) m_q[4 + i] <= res[i];
        ift_pkg::D_MC: m_q[8] <= res[0];
        ift_pkg::D_W:  for (int i = 0; i < 3; i++) w_q[i] <= res[i];
        ift_pkg::D_AT: for (int i = 0; i < 3; i++) at_q[i] <= res[i];
        ift_pkg::D_C:  for (int i = 0; i < 3; i++) c_q[i] <= res[i];
        ift_pkg::D_D:  for (int i = 0; i < 3; i++) d_q[i] <= res[i];
        ift_pkg::D_T0: for (int i = 0; i < 3; i++) t_q[3 * i] <= res[i];
        ift_pkg::D_T1: for (int i = 0; i < 3; i++) t_q[3 * i + 1] <= res[i];
        ift_pkg::D_T2: for (int i = 0; i < 3; i++) t_q[3 * i + 2] <= res[i];
        ift_pkg::D_QO: begin
          kind_q <= ift_pkg::KIND_SAMPLE;
          last_q <= 1'b1;
          for (int i = 0; i < 3; i++) begin
            ovec_q[i]  <= accel[i];
            orate_q[i] <= w_q[i];
          end
          for (int i = 0; i < 4; i++) oquat_q[i] <= res[i];
        end
        default: begin
          // covariance output rows
          kind_q <= ift_pkg::KIND_COV;
          last_q <= (dest_q == ift_pkg::D_P2);
          for (int i = 0; i < 3; i++) begin
            ovec_q[i]  <= res[i];
            orate_q[i] <= '0;
          end
          for (int i = 0; i < 4; i++) oquat_q[i] <= '0;
        end
      endcase
    end
  end

  assign out_valid_o  = out_valid_q;
  assign kind_o       = kind_q;
  assign last_o       = last_q;
  assign out_vec_x_o  = ovec_q[0];
  assign out_vec_y_o  = ovec_q[1];
  assign out_vec_z_o  = ovec_q[2];
  assign out_rate_x_o = orate_q[0];
  assign out_rate_y_o = orate_q[1];
  assign out_rate_z_o = orate_q[2];
  assign out_quat_w_o = oquat_q[0];
  assign out_quat_x_o = oquat_q[1];
  assign out_quat_y_o = oquat_q[2];
  assign out_quat_z_o = oquat_q[3];

endmodule

[src/ift_lane.sv]
// One multiply, round and accumulate lane.
module ift_lane #(
  parameter int FRAC_BITS = 16
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  ift_pkg::lane_ctl_t               ctl_i,
  input  logic signed [31:0]               a_i,
  input  logic signed [31:0]               b_i,
  output logic signed [ift_pkg::ACC_W-1:0] acc_o
);

  localparam logic signed [ift_pkg::ACC_W-1:0] ONE = 64'sd1 <<< 30;

  ift_pkg::lane_ctl_t               ctl_q;
  logic signed [ift_pkg::ACC_W-1:0] prod_q;
  logic signed [ift_pkg::ACC_W-1:0] acc_q, acc_d;
  logic signed [ift_pkg::ACC_W-1:0] half, sum, term, base;

  always_comb begin
    case (ctl_q.op.sh)
      ift_pkg::K29: half = 64'sd1 <<< 28;
      ift_pkg::K30: half = 64'sd1 <<< 29;
      default:      half = 64'sd1 <<< (FRAC_BITS - 1);
    endcase
    sum = prod_q + half;
    case (ctl_q.op.sh)
      ift_pkg::K29: term = sum >>> 29;
      ift_pkg::K30: term = sum >>> 30;
      default:      term = sum >>> FRAC_BITS;
    endcase
    base = ctl_q.first ? (ctl_q.op.bias ? ONE : '0) : acc_q;
    acc_d = ctl_q.op.neg ? base - term : base + term;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
    end else begin
      ctl_q <= ctl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= a_i * b_i;
    if (ctl_q.valid) begin
      acc_q <= acc_d;
    end
  end

  assign acc_o = acc_q;

endmodule

[src/ift_merge.sv]
// Saturates the lane sums and forms the lever-arm corrected acceleration.
module ift_merge #(
  parameter int VEC_W = 32
) (
  input  logic signed [ift_pkg::ACC_W-1:0] acc_i   [4],
  input  logic                             wide_i,
  input  logic signed [31:0]               at_i    [3],
  input  logic signed [31:0]               dd_i    [3],
  output logic signed [31:0]               res_o   [4],
  output logic signed [31:0]               accel_o [3]
);

  localparam logic signed [ift_pkg::ACC_W-1:0] VMAX = (64'sd1 <<< (VEC_W - 1)) - 64'sd1;
  localparam logic signed [ift_pkg::ACC_W-1:0] VMIN = -(64'sd1 <<< (VEC_W - 1));
  localparam logic signed [ift_pkg::ACC_W-1:0] WMAX = (64'sd1 <<< 31) - 64'sd1;
  localparam logic signed [ift_pkg::ACC_W-1:0] WMIN = -(64'sd1 <<< 31);

  function automatic logic signed [31:0] satw(logic signed [ift_pkg::ACC_W-1:0] v,
                                              logic wide);
    logic signed [ift_pkg::ACC_W-1:0] hi, lo, c;
    hi = wide ? WMAX : VMAX;
    lo = wide ? WMIN : VMIN;
    c = (v > hi) ? hi : ((v < lo) ? lo : v);
    return c[31:0];
  endfunction

  logic signed [ift_pkg::ACC_W-1:0] diff [3];

  always_comb begin
    for (int l = 0; l < 4; l++) begin
      res_o[l] = satw(acc_i[l], wide_i);
    end
    for (int i = 0; i < 3; i++) begin
      diff[i] = ift_pkg::ACC_W'(at_i[i]) - ift_pkg::ACC_W'(dd_i[i]);
      accel_o[i] = satw(diff[i], 1'b0);
    end
  end

endmodule

[src/ift_checker.sv]
// Port-level checks for the IMU frame transform, bound to the top level.
module ift_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_stall_o,
  input logic               action_i,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input logic               kind_o,
  input logic               last_o,
  input logic signed [31:0] out_vec_x_o
);

  // hold a stalled result beat
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result beat dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(out_vec_x_o) && $stable(kind_o))
    else $error("stalled result beat changed");

  a_sample_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && action_i == ift_pkg::ACT_SAMPLE |=> in_stall_o)
    else $error("sample beat accepted but block not busy");

  a_sample_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o == ift_pkg::KIND_SAMPLE |-> last_o)
    else $error("sample result without last");

endmodule

bind imu_frame_transform ift_checker u_ift_checker (.*);

[dv/testbench.sv]
// Self-checking testbench for the IMU frame transform: directed and random beats.
module testbench;

  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic              act;
    logic signed [31:0] v[3];
    logic signed [31:0] r[3];
    logic signed [31:0] q[4];
    logic [1:0]         row;
  } imu_beat_t;

  typedef struct {
    logic              kind;
    logic signed [31:0] v[3];
    logic signed [31:0] r[3];
    logic signed [31:0] q[4];
    logic              last;
  } frame_out_t;

  class frame_scoreboard;
    frame_out_t  pending[$];
    longint      mount[4];
    longint      lever[3];
    longint      cov[6];
    int          errors;
    int          checked;
    int          n_samples;
    int          n_cov;

    function new();
      mount = '{64'sd1 << 30, 0, 0, 0};
      lever = '{0, 0, 0};
      cov = '{0, 0, 0, 0, 0, 0};
      errors = 0;
      checked = 0;
      n_samples = 0;
      n_cov = 0;
    endfunction

    function longint rnd(longint p, int k);
      return (p + (64'sd1 << (k - 1))) >>> k;
    endfunction

    function longint sat32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
    endfunction

    function void set_reg(logic [2:0] idx, logic [31:0] data);
      longint s;
      s = longint'(signed'(data));
      case (idx)
        ift_pkg::CFG_QW: mount[0] = s;
        ift_pkg::CFG_QX: mount[1] = s;
        ift_pkg::CFG_QY: mount[2] = s;
        ift_pkg::CFG_QZ: mount[3] = s;
        ift_pkg::CFG_OX: lever[0] = s;
        ift_pkg::CFG_OY: lever[1] = s;
        ift_pkg::CFG_OZ: lever[2] = s;
        default: ;
      endcase
    endfunction

    function void rot_matrix(output longint m[3][3]);
      longint w, x, y, z, xx, yy, zz, xy, xz, yz, wx, wy, wz, one;
      w = mount[0]; x = mount[1]; y = mount[2]; z = mount[3];
      one = 64'sd1 << 30;
      xx = rnd(x * x, 29); yy = rnd(y * y, 29); zz = rnd(z * z, 29);
      xy = rnd(x * y, 29); xz = rnd(x * z, 29); yz = rnd(y * z, 29);
      wx = rnd(w * x, 29); wy = rnd(w * y, 29); wz = rnd(w * z, 29);
      m[0][0] = sat32(one - (yy + zz));
      m[0][1] = sat32(xy - wz);
      m[0][2] = sat32(xz + wy);
      m[1][0] = sat32(xy + wz);
      m[1][1] = sat32(one - (xx + zz));
      m[1][2] = sat32(yz - wx);
      m[2][0] = sat32(xz - wy);
      m[2][1] = sat32(yz + wx);
      m[2][2] = sat32(one - (xx + yy));
    endfunction

    function void mat_vec(longint m[3][3], longint a[3], output longint o[3]);
      longint s;
      for (int i = 0; i < 3; i++) begin
        s = 0;
        for (int j = 0; j < 3; j++) s += rnd(m[i][j] * a[j], 30);
        o[i] = sat32(s);
      end
    endfunction

    function void cross3(longint a[3], longint b[3], output longint o[3]);
      o[0] = sat32(rnd(a[1] * b[2], 16) - rnd(a[2] * b[1], 16));
      o[1] = sat32(rnd(a[2] * b[0], 16) - rnd(a[0] * b[2], 16));
      o[2] = sat32(rnd(a[0] * b[1], 16) - rnd(a[1] * b[0], 16));
    endfunction

    // Work out the results one input beat causes and queue them.
    function void note_input(imu_beat_t b);
      longint m[3][3];
      longint va[3], ra[3], w[3], at[3], c[3], d[3], col[3], tc[3], p[3], t[3][3];
      longint qi[4], qo[4];
      frame_out_t o;
      for (int i = 0; i < 3; i++) begin
        va[i] = longint'(b.v[i]);
        ra[i] = longint'(b.r[i]);
      end
      for (int i = 0; i < 4; i++) qi[i] = longint'(b.q[i]);
      rot_matrix(m);
      if (b.act == ift_pkg::ACT_SAMPLE) begin
        mat_vec(m, ra, w);
        mat_vec(m, va, at);
        cross3(w, lever, c);
        cross3(w, c, d);
        qo[0] = sat32(rnd(mount[0] * qi[0], 30) - rnd(mount[1] * qi[1], 30)
                      - rnd(mount[2] * qi[2], 30) - rnd(mount[3] * qi[3], 30));
        qo[1] = sat32(rnd(mount[0] * qi[1], 30) + rnd(mount[1] * qi[0], 30)
                      + rnd(mount[2] * qi[3], 30) - rnd(mount[3] * qi[2], 30));
        qo[2] = sat32(rnd(mount[0] * qi[2], 30) - rnd(mount[1] * qi[3], 30)
                      + rnd(mount[2] * qi[0], 30) + rnd(mount[3] * qi[1], 30));
        qo[3] = sat32(rnd(mount[0] * qi[3], 30) + rnd(mount[1] * qi[2], 30)
                      - rnd(mount[2] * qi[1], 30) + rnd(mount[3] * qi[0], 30));
        o.kind = ift_pkg::KIND_SAMPLE;
        o.last = 1'b1;
        for (int i = 0; i < 3; i++) begin
          o.v[i] = 32'(sat32(at[i] - d[i]));
          o.r[i] = 32'(w[i]);
        end
        for (int i = 0; i < 4; i++) o.q[i] = 32'(qo[i]);
        pending.push_back(o);
        n_samples++;
        return;
      end
      if (b.row == ift_pkg::ROW_0 || b.row == ift_pkg::ROW_1) begin
        for (int i = 0; i < 3; i++) cov[b.row * 3 + i] = va[i];
        return;
      end
      if (b.row != ift_pkg::ROW_2) return;
      // T = M*C column by column, then each row of T times M^T
      for (int j = 0; j < 3; j++) begin
        col[0] = cov[j];
        col[1] = cov[3 + j];
        col[2] = va[j];
        mat_vec(m, col, tc);
        for (int i = 0; i < 3; i++) t[i][j] = tc[i];
      end
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) col[j] = t[i][j];
        mat_vec(m, col, p);
        o.kind = ift_pkg::KIND_COV;
        o.last = (i == 2);
        for (int k = 0; k < 3; k++) begin
          o.v[k] = 32'(p[k]);
          o.r[k] = '0;
        end
        for (int k = 0; k < 4; k++) o.q[k] = '0;
        pending.push_back(o);
      end
      n_cov++;
    endfunction

    task report(string what, logic [31:0] got, logic [31:0] want);
      $display("mismatch at %0t: %s got %h expected %h", $realtime, what, got, want);
      errors++;
    endtask

    task check_result(frame_out_t got);
      frame_out_t e;
      checked++;
      if (pending.size() == 0) begin
        report("result beat with nothing expected, kind", 32'(got.kind), 32'(got.kind));
        return;
      end
      e = pending.pop_front();
      if (got.kind !== e.kind) report("kind", 32'(got.kind), 32'(e.kind));
      if (got.last !== e.last) report("last", 32'(got.last), 32'(e.last));
      for (int i = 0; i < 3; i++) begin
        if (got.v[i] !== e.v[i]) report($sformatf("out_vec[%0d]", i), got.v[i], e.v[i]);
        if (got.r[i] !== e.r[i]) report($sformatf("out_rate[%0d]", i), got.r[i], e.r[i]);
      end
      for (int i = 0; i < 4; i++) begin
        if (got.q[i] !== e.q[i]) report($sformatf("out_quat[%0d]", i), got.q[i], e.q[i]);
      end
    endtask
  endclass

  logic               clk_i = 1'b0;
  logic               rst_ni;
  logic               cfg_we_i;
  logic [2:0]         cfg_idx_i;
  logic [31:0]        cfg_data_i;
  logic               in_valid_i;
  logic               in_stall_o;
  logic               action_i;
  logic signed [31:0] vec_x_i, vec_y_i, vec_z_i;
  logic signed [31:0] rate_x_i, rate_y_i, rate_z_i;
  logic signed [31:0] quat_w_i, quat_x_i, quat_y_i, quat_z_i;
  logic [1:0]         row_i;
  logic               out_valid_o;
  logic               out_stall_i;
  logic               kind_o;
  logic signed [31:0] out_vec_x_o, out_vec_y_o, out_vec_z_o;
  logic signed [31:0] out_rate_x_o, out_rate_y_o, out_rate_z_o;
  logic signed [31:0] out_quat_w_o, out_quat_x_o, out_quat_y_o, out_quat_z_o;
  logic               last_o;

  frame_scoreboard sb = new();
  int  send_idle_pct = 0;
  int  stall_pct = 0;
  int  beats_sent = 0;
  int  settings_used = 0;
  bit  rows_loaded[2] = '{1'b0, 1'b0};

  always #6 clk_i = ~clk_i;

  imu_frame_transform i_dut (.*);

  // Receiver: check each accepted result beat, then pick the next stall.
  always @(posedge clk_i) begin
    frame_out_t r;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      r.kind = kind_o;
      r.last = last_o;
      r.v = '{out_vec_x_o, out_vec_y_o, out_vec_z_o};
      r.r = '{out_rate_x_o, out_rate_y_o, out_rate_z_o};
      r.q = '{out_quat_w_o, out_quat_x_o, out_quat_y_o, out_quat_z_o};
      sb.check_result(r);
    end
    out_stall_i <= ($urandom_range(99) < stall_pct);
  end

  initial begin
    #20ms;
    $display("timeout with %0d results still expected", sb.pending.size());
    $display("testbench failed");
    $finish;
  end

  function automatic logic [31:0] pick_word(int style);
    case (style)
      0: return $urandom;
      1: return 32'($signed($urandom_range(32'h0004_0000)) - 32'sh0002_0000);
      2: begin
        case ($urandom_range(3))
          0: return 32'h7fff_ffff;
          1: return 32'h8000_0000;
          2: return 32'h0000_0000;
          default: return 32'hffff_ffff;
        endcase
      end
      default: return 32'($signed($urandom_range(32'h8000_0000)) - 32'sh4000_0000);
    endcase
  endfunction

  task automatic send_beat(imu_beat_t b);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    action_i <= b.act;
    {vec_x_i, vec_y_i, vec_z_i} <= {b.v[0], b.v[1], b.v[2]};
    {rate_x_i, rate_y_i, rate_z_i} <= {b.r[0], b.r[1], b.r[2]};
    {quat_w_i, quat_x_i, quat_y_i, quat_z_i} <= {b.q[0], b.q[1], b.q[2], b.q[3]};
    row_i <= b.row;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_input(b);
    if (b.act == ift_pkg::ACT_COV && b.row < ift_pkg::ROW_2) rows_loaded[b.row] = 1'b1;
    if (b.act == ift_pkg::ACT_SAMPLE || b.row != 2'd3) beats_sent++;
  endtask

  function automatic imu_beat_t make_beat(logic act, logic [1:0] row, int style);
    imu_beat_t b;
    b.act = act;
    b.row = row;
    for (int i = 0; i < 3; i++) begin
      b.v[i] = pick_word(style < 0 ? $urandom_range(3) : style);
      b.r[i] = pick_word(style < 0 ? $urandom_range(3) : style);
    end
    for (int i = 0; i < 4; i++) b.q[i] = pick_word(style < 0 ? 3 : style);
    return b;
  endfunction

  // Drop valid, hold until every result is in, then let a row-store beat settle.
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (80) @(posedge clk_i);
  endtask

  task automatic write_regs(logic [31:0] vals[7]);
    logic [2:0] idx[7];
    idx = '{ift_pkg::CFG_QW, ift_pkg::CFG_QX, ift_pkg::CFG_QY, ift_pkg::CFG_QZ,
            ift_pkg::CFG_OX, ift_pkg::CFG_OY, ift_pkg::CFG_OZ};
    for (int i = 0; i < 7; i++) begin
      cfg_we_i <= 1'b1;
      cfg_idx_i <= idx[i];
      cfg_data_i <= vals[i];
      @(posedge clk_i);
      sb.set_reg(idx[i], vals[i]);
    end
    cfg_we_i <= 1'b0;
    settings_used++;
  endtask

  initial begin
    imu_beat_t b;
    logic [31:0] regs[7];
    int c;
    rst_ni <= 1'b0;
    cfg_we_i <= 1'b0;
    cfg_idx_i <= ift_pkg::CFG_QW;
    cfg_data_i <= '0;
    in_valid_i <= 1'b0;
    action_i <= ift_pkg::ACT_SAMPLE;
    {vec_x_i, vec_y_i, vec_z_i, rate_x_i, rate_y_i, rate_z_i} <= '0;
    {quat_w_i, quat_x_i, quat_y_i, quat_z_i} <= '0;
    row_i <= ift_pkg::ROW_0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: reset mounting, extremes, every row, the ignored row index.
    for (int s = 0; s < 4; s++) begin
      b = make_beat(ift_pkg::ACT_SAMPLE, ift_pkg::ROW_0, 2);
      for (int i = 0; i < 3; i++) begin
        b.v[i] = (s == 0) ? 32'h7fff_ffff : (s == 1) ? 32'h8000_0000 : b.v[i];
        b.r[i] = (s == 0) ? 32'h7fff_ffff : (s == 1) ? 32'h8000_0000 : b.r[i];
      end
      send_beat(b);
    end
    send_beat(make_beat(ift_pkg::ACT_COV, 2'd3, 2));
    send_beat(make_beat(ift_pkg::ACT_COV, ift_pkg::ROW_0, 2));
    send_beat(make_beat(ift_pkg::ACT_COV, ift_pkg::ROW_1, 2));
    send_beat(make_beat(ift_pkg::ACT_COV, ift_pkg::ROW_2, 2));
    send_beat(make_beat(ift_pkg::ACT_COV, ift_pkg::ROW_2, 0));
    wait_drained();
    regs = '{32'h4000_0000, 32'h0, 32'h0, 32'h0, 32'h7fff_ffff, 32'h8000_0000, 32'h0001_0000};
    write_regs(regs);
    send_beat(make_beat(ift_pkg::ACT_SAMPLE, ift_pkg::ROW_0, 0));
    send_beat(make_beat(ift_pkg::ACT_SAMPLE, ift_pkg::ROW_0, 2));
    regs = '{32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff,
             32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000};
    wait_drained();
    write_regs(regs);
    send_beat(make_beat(ift_pkg::ACT_SAMPLE, ift_pkg::ROW_0, 2));
    send_beat(make_beat(ift_pkg::ACT_COV, ift_pkg::ROW_0, 2));
    send_beat(make_beat(ift_pkg::ACT_COV, ift_pkg::ROW_1, 2));
    send_beat(make_beat(ift_pkg::ACT_COV, ift_pkg::ROW_2, 2));

    // Random phases: each with its own mounting and one of four idle and stall patterns.
    for (int ph = 0; ph < 8; ph++) begin
      wait_drained();
      case (ph % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 83; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 83; end
        default: begin send_idle_pct = 34; stall_pct = 34; end
      endcase
      for (int i = 0; i < 4; i++) regs[i] = pick_word(ph == 7 ? 0 : (ph == 3 ? 2 : 3));
      for (int i = 4; i < 7; i++) regs[i] = pick_word(ph == 5 ? 2 : $urandom_range(1) ? 1 : 0);
      write_regs(regs);
      c = 0;
      while (c < 32) begin
        case ($urandom_range(9))
          0, 1, 2, 3, 4: begin
            send_beat(make_beat(ift_pkg::ACT_SAMPLE, 2'($urandom_range(3)), -1));
            c++;
          end
          5, 6, 7: begin
            send_beat(make_beat(ift_pkg::ACT_COV, ift_pkg::ROW_0, -1));
            send_beat(make_beat(ift_pkg::ACT_COV, ift_pkg::ROW_1, -1));
            send_beat(make_beat(ift_pkg::ACT_COV, ift_pkg::ROW_2, -1));
            c += 3;
          end
          default: begin
            // noise: lone rows, the ignored index, or a repeated row 2
            c++;
            b = make_beat(ift_pkg::ACT_COV, 2'($urandom_range(3)), -1);
            if (b.row == ift_pkg::ROW_2 && !(rows_loaded[0] && rows_loaded[1])) begin
              b.row = ift_pkg::ROW_0;
            end
            send_beat(b);
          end
        endcase
      end
    end

    wait_drained();
    $display("%0d input beats: %0d samples, %0d covariance sets, %0d result beats checked",
             beats_sent, sb.n_samples, sb.n_cov, sb.checked);
    $display("%0d register settings across four idle and stall patterns", settings_used);
    if (sb.errors == 0) begin
      $display("testbench passed");
    end else begin
      $display("%0d mismatches", sb.errors);
      $display("testbench failed");
    end
    $finish;
  end
endmodule

[files.f]
src/ift_pkg.sv
src/ift_lane.sv
src/ift_merge.sv
src/imu_frame_transform.sv
src/ift_checker.sv
dv/testbench.sv
